// ----- rtl/bfdh_pkg.sv -----
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared types, codes and hash constants for the double-hash Bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

   // Operation codes carried by a request beat.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_FILTER_ENABLE = 2'd0,
      CSR_BIT_COUNT     = 2'd1,
      CSR_HASH_COUNT    = 2'd2
   } csr_idx_type;

   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 17;
   localparam int BIT_COUNT_W  = 17;
   localparam int HASH_COUNT_W = 4;

   // Register reset values.
   localparam logic                    FILTER_ENABLE_RST = 1'b1;
   localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST     = 17'd1024;
   localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST    = 4'd6;

   // FNV-1a constants and the two seeds.
   localparam int          HASH_W    = 32;
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [31:0] SEED_ONE  = 32'h811C9DC5;
   localparam logic [31:0] SEED_TWO  = 32'h9E3779B9;
   localparam logic [31:0] HASH1_INIT = FNV_BASIS ^ SEED_ONE;
   localparam logic [31:0] HASH2_INIT = FNV_BASIS ^ SEED_TWO;

   // Remainder unit: quotient bits retired per cycle, divide steps per probe and step counter width.
   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES         = HASH_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_ACCESS,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic load_first;
      logic load_next;
      logic div_step;
      logic mem_wr;
      logic mem_rd;
      logic check;
      logic clr_step;
      logic rsp_load;
      logic hash_restart;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic active;
      logic is_query;
      logic div_last;
      logic last_probe;
      logic clr_last;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- rtl/bfdh_req_if.sv -----
// ----------------------------------------------------------------------------
// Bloom filter request channel
// Valid/ready channel carrying one key byte and its operation per beat.
// ----------------------------------------------------------------------------
interface bfdh_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] key_byte;
   logic       byte_valid;
   logic       key_last;

   modport source (
      output valid, operation, key_byte, byte_valid, key_last,
      input  ready
   );
   modport sink (
      input  valid, operation, key_byte, byte_valid, key_last,
      output ready
   );
endinterface

// ----- rtl/bfdh_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Bloom filter response channel
// Valid/ready channel carrying the finished operation and the query answer.
// ----------------------------------------------------------------------------
interface bfdh_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] done_operation;
   logic       maybe_present;

   modport source (
      output valid, done_operation, maybe_present,
      input  ready
   );
   modport sink (
      input  valid, done_operation, maybe_present,
      output ready
   );
endinterface

// ----- rtl/bfdh_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfdh_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bfdh_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bloom filter controller
// Sequences key hashing, the per-probe remainder and memory access, the
// store clearing pass and the hand-off of each result.
// ----------------------------------------------------------------------------
module bfdh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_operation,
   input  logic                   req_key_last,
   output logic                   req_ready,
   input  bfdh_pkg::dp_status_type status,
   output bfdh_pkg::ctrl_cmd_type  cmd
);

   bfdh_pkg::state_type state_ff, state_in;
   logic                resp_pend_ff, resp_pend_in;

   // State register. Reset starts with a pass that zeroes the bit store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfdh_pkg::ST_CLEAR;
         resp_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resp_pend_ff <= resp_pend_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      resp_pend_in = resp_pend_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         bfdh_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               resp_pend_in = 1'b0;
               state_in     = resp_pend_ff ? bfdh_pkg::ST_DONE : bfdh_pkg::ST_IDLE;
            end
         end
         bfdh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (bfdh_pkg::op_type'(req_operation))
                  bfdh_pkg::OP_CLEAR: begin
                     resp_pend_in = 1'b1;
                     state_in     = bfdh_pkg::ST_CLEAR;
                  end
                  bfdh_pkg::OP_INSERT, bfdh_pkg::OP_QUERY: begin
                     if (req_key_last) begin
                        state_in = status.active ? bfdh_pkg::ST_LOAD : bfdh_pkg::ST_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bfdh_pkg::ST_LOAD: begin
            cmd.load_first = 1'b1;
            state_in       = bfdh_pkg::ST_DIV;
         end
         bfdh_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = bfdh_pkg::ST_ACCESS;
            end
         end
         bfdh_pkg::ST_ACCESS: begin
            if (status.is_query) begin
               cmd.mem_rd = 1'b1;
               state_in   = bfdh_pkg::ST_CHECK;
            end else begin
               cmd.mem_wr = 1'b1;
               if (status.last_probe) begin
                  state_in = bfdh_pkg::ST_DONE;
               end else begin
                  cmd.load_next = 1'b1;
                  state_in      = bfdh_pkg::ST_DIV;
               end
            end
         end
         bfdh_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.last_probe) begin
               state_in = bfdh_pkg::ST_DONE;
            end else begin
               cmd.load_next = 1'b1;
               state_in      = bfdh_pkg::ST_DIV;
            end
         end
         bfdh_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load     = 1'b1;
               cmd.hash_restart = 1'b1;
               state_in         = bfdh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfdh_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/bfdh_dp.sv -----
// ----------------------------------------------------------------------------
// Bloom filter datapath
// Configuration registers, running hashes, probe sum, remainder unit,
// bit store and the response output register.
// ----------------------------------------------------------------------------
module bfdh_dp #(
   parameter int MAX_BITS   = 65536,
   parameter int MAX_PROBES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bfdh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfdh_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [1:0]                          req_operation,
   input  logic [7:0]                          req_key_byte,
   input  logic                                req_byte_valid,
   input  bfdh_pkg::ctrl_cmd_type              cmd,
   output bfdh_pkg::dp_status_type             status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_done_operation,
   output logic                                rsp_maybe_present
);

   localparam int AW  = $clog2(MAX_BITS);
   localparam int NW  = $clog2(MAX_BITS + 1);
   localparam int PCW = $clog2(MAX_PROBES + 1);
   localparam int HW  = bfdh_pkg::HASH_W;

   // Configuration registers.
   logic                              enable_ff, enable_in;
   logic [bfdh_pkg::BIT_COUNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [bfdh_pkg::HASH_COUNT_W-1:0] hash_count_ff, hash_count_in;

   // Hash, probe and remainder state.
   logic [HW-1:0]                  h1_ff, h1_in, h2_ff, h2_in, h2_odd;
   logic [HW-1:0]                  sum_ff, sum_in, dvd_ff, dvd_in;
   logic [NW-1:0]                  rem_ff, rem_in;
   logic [bfdh_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [PCW-1:0]                 probe_cnt_ff, probe_cnt_in;
   logic [AW-1:0]                  clr_addr_ff, clr_addr_in;
   logic [1:0]                     op_ff, op_in;
   logic                           answer_ff, answer_in;

   // Response output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_op_ff, rsp_op_in;
   logic                           rsp_maybe_ff, rsp_maybe_in;

   logic [NW-1:0]  nbits;
   logic [PCW-1:0] nprobes;
   logic [HW-1:0]  key_word;
   logic           hashable;
   logic           rd_bit;
   logic           ram_wr_en;
   logic [AW-1:0]  ram_wr_addr;
   logic           ram_wr_data;

   // Effective counts, clamped to the store and probe limits.
   always_comb begin
      nbits   = (32'(bit_count_ff) > 32'(MAX_BITS)) ? NW'(MAX_BITS) : NW'(bit_count_ff);
      nprobes = (32'(hash_count_ff) > 32'(MAX_PROBES)) ?
                PCW'(MAX_PROBES) : PCW'(hash_count_ff);
   end

   // Configuration writes.
   always_comb begin
      enable_in     = enable_ff;
      bit_count_in  = bit_count_ff;
      hash_count_in = hash_count_ff;
      if (csr_wr_en) begin
         case (bfdh_pkg::csr_idx_type'(csr_index))
            bfdh_pkg::CSR_FILTER_ENABLE: enable_in = csr_wdata[0];
            bfdh_pkg::CSR_BIT_COUNT:     bit_count_in = csr_wdata[bfdh_pkg::BIT_COUNT_W-1:0];
            bfdh_pkg::CSR_HASH_COUNT:    hash_count_in = csr_wdata[bfdh_pkg::HASH_COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Running FNV-1a hashes over key bytes of insert and query beats.
   always_comb begin
      key_word = {{(HW - 8){1'b0}}, req_key_byte};
      hashable = cmd.accept && req_byte_valid &&
                 (bfdh_pkg::op_type'(req_operation) == bfdh_pkg::OP_INSERT ||
                  bfdh_pkg::op_type'(req_operation) == bfdh_pkg::OP_QUERY);
      h1_in = h1_ff;
      h2_in = h2_ff;
      if (cmd.hash_restart) begin
         h1_in = bfdh_pkg::HASH1_INIT;
         h2_in = bfdh_pkg::HASH2_INIT;
      end else if (hashable) begin
         h1_in = HW'((h1_ff ^ key_word) * bfdh_pkg::FNV_PRIME);
         h2_in = HW'((h2_ff ^ key_word) * bfdh_pkg::FNV_PRIME);
      end
   end

   assign h2_odd = h2_ff | HW'(1);

   // Probe sum and the remainder unit, several quotient bits per cycle.
   always_comb begin
      logic [NW-1:0] r;
      logic [NW:0]   t;
      logic [HW-1:0] d;
      sum_in       = sum_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      probe_cnt_in = probe_cnt_ff;
      r            = rem_ff;
      d            = dvd_ff;
      t            = '0;
      if (cmd.load_first) begin
         dvd_in       = h1_ff;
         sum_in       = h1_ff + h2_odd;
         rem_in       = '0;
         div_cnt_in   = '0;
         probe_cnt_in = '0;
      end else if (cmd.load_next) begin
         dvd_in       = sum_ff;
         sum_in       = sum_ff + h2_odd;
         rem_in       = '0;
         div_cnt_in   = '0;
         probe_cnt_in = probe_cnt_ff + PCW'(1);
      end else if (cmd.div_step) begin
         for (int k = 0; k < bfdh_pkg::DIV_BITS_PER_CYCLE; k++) begin
            t = {r, d[HW-1]};
            d = {d[HW-2:0], 1'b0};
            if (t >= {1'b0, nbits}) begin
               t = t - {1'b0, nbits};
            end
            r = t[NW-1:0];
         end
         dvd_in     = d;
         rem_in     = r;
         div_cnt_in = div_cnt_ff + bfdh_pkg::DIV_CNT_W'(1);
      end
   end

   // Latched operation and query answer.
   always_comb begin
      op_in     = op_ff;
      answer_in = answer_ff;
      if (cmd.accept) begin
         op_in     = req_operation;
         answer_in = 1'b1;
      end else if (cmd.check && !rd_bit) begin
         answer_in = 1'b0;
      end
   end

   // Clearing sweep address.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clr_step) begin
         clr_addr_in = status.clr_last ? '0 : clr_addr_ff + AW'(1);
      end
   end

   // Output register; a new result loads as the old one leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_op_in    = rsp_op_ff;
      rsp_maybe_in = rsp_maybe_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_op_in    = op_ff;
         rsp_maybe_in = (bfdh_pkg::op_type'(op_ff) == bfdh_pkg::OP_QUERY) && answer_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Status toward the controller.
   always_comb begin
      status.active     = enable_ff && (bit_count_ff != '0) && (hash_count_ff != '0);
      status.is_query   = (bfdh_pkg::op_type'(op_ff) == bfdh_pkg::OP_QUERY);
      status.div_last   = (div_cnt_ff == bfdh_pkg::DIV_CNT_W'(bfdh_pkg::DIV_CYCLES - 1));
      status.last_probe = (PCW'(probe_cnt_ff + PCW'(1)) == nprobes);
      status.clr_last   = (clr_addr_ff == AW'(MAX_BITS - 1));
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= bfdh_pkg::FILTER_ENABLE_RST;
         bit_count_ff  <= bfdh_pkg::BIT_COUNT_RST;
         hash_count_ff <= bfdh_pkg::HASH_COUNT_RST;
         h1_ff         <= bfdh_pkg::HASH1_INIT;
         h2_ff         <= bfdh_pkg::HASH2_INIT;
         div_cnt_ff    <= '0;
         probe_cnt_ff  <= '0;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         bit_count_ff  <= bit_count_in;
         hash_count_ff <= hash_count_in;
         h1_ff         <= h1_in;
         h2_ff         <= h2_in;
         div_cnt_ff    <= div_cnt_in;
         probe_cnt_ff  <= probe_cnt_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      op_ff        <= op_in;
      answer_ff    <= answer_in;
      rsp_op_ff    <= rsp_op_in;
      rsp_maybe_ff <= rsp_maybe_in;
   end

   // Bit store: the clearing sweep and insert probes share the write port.
   always_comb begin
      ram_wr_en   = cmd.clr_step || cmd.mem_wr;
      ram_wr_addr = cmd.clr_step ? clr_addr_ff : rem_ff[AW-1:0];
      ram_wr_data = !cmd.clr_step;
   end

   bfdh_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.mem_rd),
      .rd_addr (rem_ff[AW-1:0]),
      .rd_data (rd_bit)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_done_operation = rsp_op_ff;
   assign rsp_maybe_present  = rsp_maybe_ff;

endmodule

// ----- rtl/bloom_filter_double_hash_core.sv -----
// ----------------------------------------------------------------------------
// Bloom filter with double hashing
// Channel   Dir   Handshake      Payload
// req_if    in    valid/ready    operation, key_byte, byte_valid, key_last
// rsp_if    out   valid/ready    done_operation, maybe_present
// csr       in    csr_wr_en      csr_index, csr_wdata
//
// A beat that does not end a key is taken in the idle state and feeds its byte,
// if valid, to the running hashes. With the filter active, a key end loads the
// probe sum and then, for each probe, runs the remainder unit (four bits a
// cycle) and uses the single-bit store port: a write for an insert, a read and
// check for a query. A clear sweeps the store one bit per cycle; after reset the
// same sweep runs before the first request beat is taken.
// A result waits in the output register; the next beats are taken meanwhile.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_core #(
   parameter int MAX_BITS   = 65536,
   parameter int MAX_PROBES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   bfdh_req_if.sink                         req_if,
   bfdh_rsp_if.source                       rsp_if,
   input  logic                             csr_wr_en,
   input  logic [bfdh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfdh_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bfdh_pkg::ctrl_cmd_type  cmd;
   bfdh_pkg::dp_status_type status;

   // Controller.
   bfdh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_operation (req_if.operation),
      .req_key_last  (req_if.key_last),
      .req_ready     (req_if.ready),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath.
   bfdh_dp #(
      .MAX_BITS   (MAX_BITS),
      .MAX_PROBES (MAX_PROBES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_operation      (req_if.operation),
      .req_key_byte       (req_if.key_byte),
      .req_byte_valid     (req_if.byte_valid),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_if.ready),
      .rsp_valid          (rsp_if.valid),
      .rsp_done_operation (rsp_if.done_operation),
      .rsp_maybe_present  (rsp_if.maybe_present)
   );

endmodule

// ----- dv/bloom_filter_double_hash_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bloom filter double-hash core testbench
// Sends keys one byte per beat, predicts every response with an in-bench copy
// of the filter and checks the responses in order. The run covers several
// register settings, random stalls on both channels and a long response hold.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_core_tb;

   localparam int         MAX_BITS         = 65536;
   localparam int         MAX_PROBES       = 8;
   localparam logic [1:0] OP_UNUSED        = 2'd3;
   localparam int         SETTLE_CYCLES    = 100;
   localparam int         LONG_HOLD_CYCLES = 300;
   localparam int         WATCHDOG_LIMIT   = 4 * (MAX_BITS + 2) + 2000;
   localparam int         POOL_SIZE        = 16;
   localparam int         KEY_MAX          = 6;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] key_byte;
      logic       byte_valid;
      logic       key_last;
   } key_beat_type;

   typedef struct packed {
      logic [1:0] done_operation;
      logic       maybe_present;
   } answer_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [bfdh_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bfdh_pkg::CSR_DATA_W-1:0]  csr_wdata;

   bfdh_req_if req_if ();
   bfdh_rsp_if rsp_if ();

   bloom_filter_double_hash_core #(
      .MAX_BITS   (MAX_BITS),
      .MAX_PROBES (MAX_PROBES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Filter state and registers as the bench sees them.
   bit   [MAX_BITS-1:0]               filter_bits;
   logic [31:0]                       first_hash;
   logic [31:0]                       second_hash;
   logic                              filter_enable;
   logic [bfdh_pkg::BIT_COUNT_W-1:0]  bit_count;
   logic [bfdh_pkg::HASH_COUNT_W-1:0] hash_count;

   answer_type   expected_answers[$];
   key_beat_type key_beats_q[$];

   // Key pool, so that queries often hit keys inserted earlier.
   logic [7:0] pool_bytes [POOL_SIZE][KEY_MAX];
   int         pool_len [POOL_SIZE];
   int         beats_made;

   key_beat_type cur_beat;
   logic         beat_offered;
   logic         req_fire;
   int           src_gap;
   bit           src_idle_en;

   logic rsp_fire;
   int   snk_stall;
   bit   snk_idle_en;
   bit   hold_armed;
   bit   hold_taken;

   int fail_count;
   int quiet_cycles;

   always #10 clock = ~clock;

   // Applies one accepted beat to the filter copy and queues the response it
   // causes, if any.
   task automatic filter_apply_beat(input key_beat_type beat);
      logic [31:0] nbits;
      logic [31:0] nprobe;
      logic [31:0] stride;
      logic [31:0] pos;
      logic [31:0] idx;
      logic        hit;
      logic        active;
      answer_type  answer;
      if (beat.operation == OP_UNUSED) return;
      if (beat.operation == bfdh_pkg::OP_CLEAR) begin
         filter_bits = '0;
         first_hash = bfdh_pkg::HASH1_INIT;
         second_hash = bfdh_pkg::HASH2_INIT;
         answer.done_operation = bfdh_pkg::OP_CLEAR;
         answer.maybe_present = 1'b0;
         expected_answers = {expected_answers, answer};
         return;
      end
      if (beat.byte_valid) begin
         first_hash = (first_hash ^ {24'd0, beat.key_byte}) * bfdh_pkg::FNV_PRIME;
         second_hash = (second_hash ^ {24'd0, beat.key_byte}) * bfdh_pkg::FNV_PRIME;
      end
      if (!beat.key_last) return;

      // Key end: oversized counts are clamped, and any zero disables.
      nbits = (bit_count > MAX_BITS) ? MAX_BITS : bit_count;
      nprobe = (hash_count > MAX_PROBES) ? MAX_PROBES : hash_count;
      active = filter_enable && nbits != 0 && nprobe != 0;
      stride = second_hash | 32'd1;
      hit = 1'b1;
      if (active) begin
         for (idx = 0; idx < nprobe; idx++) begin
            pos = (first_hash + idx * stride) % nbits;
            if (beat.operation == bfdh_pkg::OP_INSERT) filter_bits[pos] = 1'b1;
            else if (!filter_bits[pos]) hit = 1'b0;
         end
      end
      answer.done_operation = beat.operation;
      answer.maybe_present = (beat.operation == bfdh_pkg::OP_QUERY) ? hit : 1'b0;
      expected_answers = {expected_answers, answer};
      first_hash = bfdh_pkg::HASH1_INIT;
      second_hash = bfdh_pkg::HASH2_INIT;
   endtask

   task automatic add_beat(input logic [1:0] op, input logic [7:0] key_byte,
                           input logic byte_valid, input logic key_last);
      key_beat_type beat;
      beat.operation = op;
      beat.key_byte = key_byte;
      beat.byte_valid = byte_valid;
      beat.key_last = key_last;
      key_beats_q = {key_beats_q, beat};
      if (op != OP_UNUSED) beats_made++;
   endtask

   // One key, new or from the pool, with now and then a mixed operation, an
   // empty beat or an ignored beat in between.
   task automatic add_random_key();
      int         slot;
      int         k;
      logic [1:0] op;
      logic [1:0] byte_op;
      logic       ends_here;
      slot = $urandom_range(0, POOL_SIZE - 1);
      op = $urandom_range(0, 1) ? bfdh_pkg::OP_QUERY : bfdh_pkg::OP_INSERT;
      if ($urandom_range(0, 2) == 0) begin
         pool_len[slot] = $urandom_range(0, KEY_MAX);
         for (k = 0; k < KEY_MAX; k++) pool_bytes[slot][k] = 8'($urandom);
      end
      ends_here = 1'b0;
      for (k = 0; k < pool_len[slot]; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) add_beat(op, 8'($urandom), 1'b0, 1'b0);
            else add_beat(OP_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
         end
         ends_here = (k == pool_len[slot] - 1) && ($urandom_range(0, 9) != 0);
         byte_op = op;
         if ($urandom_range(0, 4) == 0) begin
            byte_op = $urandom_range(0, 1) ? bfdh_pkg::OP_QUERY : bfdh_pkg::OP_INSERT;
         end
         add_beat(ends_here ? op : byte_op, pool_bytes[slot][k], 1'b1, ends_here);
      end
      // Empty keys and keys closed by a beat that carries no byte.
      if (!ends_here) add_beat(op, 8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic fill_random(input int beats, input bit with_clear);
      int goal;
      int clear_at;
      int part;
      int k;
      goal = beats_made + beats;
      clear_at = with_clear ? beats_made + $urandom_range(0, beats - 1) : -1;
      while (beats_made < goal) begin
         if (clear_at >= 0 && beats_made >= clear_at) begin
            // A clear may cut a key short.
            part = $urandom_range(0, 3);
            for (k = 0; k < part; k++) begin
               add_beat(bfdh_pkg::OP_INSERT, 8'($urandom), 1'b1, 1'b0);
            end
            add_beat(bfdh_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
            clear_at = -1;
         end else if ($urandom_range(0, 19) == 0) begin
            add_beat(OP_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            add_random_key();
         end
      end
   endtask

   // Waits until every beat is taken and every response is in, then lets the
   // block finish any beat that gives no response.
   task automatic drain();
      while (key_beats_q.size() != 0 || beat_offered || expected_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input bfdh_pkg::csr_idx_type idx,
                            input logic [bfdh_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         bfdh_pkg::CSR_FILTER_ENABLE: filter_enable = value[0];
         bfdh_pkg::CSR_BIT_COUNT:     bit_count = value[bfdh_pkg::BIT_COUNT_W-1:0];
         bfdh_pkg::CSR_HASH_COUNT:    hash_count = value[bfdh_pkg::HASH_COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic enable,
                            input logic [bfdh_pkg::CSR_DATA_W-1:0] bits,
                            input logic [bfdh_pkg::CSR_DATA_W-1:0] probes,
                            input int beats, input bit src_idle, input bit snk_idle,
                            input bit with_clear);
      write_csr(bfdh_pkg::CSR_FILTER_ENABLE, {16'd0, enable});
      write_csr(bfdh_pkg::CSR_BIT_COUNT, bits);
      write_csr(bfdh_pkg::CSR_HASH_COUNT, probes);
      src_idle_en = src_idle;
      snk_idle_en = snk_idle;
      fill_random(beats, with_clear);
      drain();
   endtask

   // Request side: a beat is taken at a rising edge with valid and ready high.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         filter_apply_beat(cur_beat);
         req_fire = 1'b1;
      end
   end

   // Request driver: after each beat it pauses for a random gap when source idling is on.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_fire) begin
            req_fire = 1'b0;
            beat_offered = 1'b0;
            src_gap = src_idle_en ? $urandom_range(0, 9) : 0;
         end
         if (!beat_offered) begin
            if (src_gap > 0) begin
               src_gap--;
            end else if (key_beats_q.size() != 0) begin
               cur_beat = key_beats_q.pop_front();
               beat_offered = 1'b1;
            end
         end
         req_if.valid      <= beat_offered;
         req_if.operation  <= cur_beat.operation;
         req_if.key_byte   <= cur_beat.key_byte;
         req_if.byte_valid <= cur_beat.byte_valid;
         req_if.key_last   <= cur_beat.key_last;
      end
   end

   // Response check: each response beat against the oldest expectation.
   always @(posedge clock) begin : answer_check
      answer_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_fire = 1'b1;
         if (expected_answers.size() == 0) begin
            $display("%0t: expected no response, actual done_operation %0d maybe_present %0b",
                     $time, rsp_if.done_operation, rsp_if.maybe_present);
            fail_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_if.done_operation !== want.done_operation) begin
               $display("%0t: done_operation expected %0d actual %0d",
                        $time, want.done_operation, rsp_if.done_operation);
               fail_count++;
            end
            if (rsp_if.maybe_present !== want.maybe_present) begin
               $display("%0t: maybe_present expected %0b actual %0b",
                        $time, want.maybe_present, rsp_if.maybe_present);
               fail_count++;
            end
         end
      end
   end

   // Response ready: a drawn stall after each beat when sink idling is on, and once a long hold.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_fire = 1'b0;
            snk_stall = snk_idle_en ? $urandom_range(0, 9) : 0;
         end
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            snk_stall = LONG_HOLD_CYCLES;
         end
         if (snk_stall > 0) begin
            snk_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("** bloom_filter_double_hash_core: FAILED **");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.operation = bfdh_pkg::OP_INSERT;
      req_if.key_byte = '0;
      req_if.byte_valid = 1'b0;
      req_if.key_last = 1'b0;
      rsp_if.ready = 1'b0;
      cur_beat = '0;
      beat_offered = 1'b0;
      req_fire = 1'b0;
      src_gap = 0;
      src_idle_en = 1'b1;
      rsp_fire = 1'b0;
      snk_stall = 0;
      snk_idle_en = 1'b1;
      hold_armed = 1'b0;
      hold_taken = 1'b0;
      fail_count = 0;
      quiet_cycles = 0;
      beats_made = 0;
      filter_bits = '0;
      first_hash = bfdh_pkg::HASH1_INIT;
      second_hash = bfdh_pkg::HASH2_INIT;
      filter_enable = bfdh_pkg::FILTER_ENABLE_RST;
      bit_count = bfdh_pkg::BIT_COUNT_RST;
      hash_count = bfdh_pkg::HASH_COUNT_RST;
      for (int s = 0; s < POOL_SIZE; s++) begin
         pool_len[s] = 0;
         for (int k = 0; k < KEY_MAX; k++) pool_bytes[s][k] = '0;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed keys under the reset settings.
      // Empty key, inserted and then queried.
      add_beat(bfdh_pkg::OP_INSERT, 8'h00, 1'b0, 1'b1);
      add_beat(bfdh_pkg::OP_QUERY,  8'hFF, 1'b0, 1'b1);
      // Extreme byte values, inserted, found, and swapped.
      add_beat(bfdh_pkg::OP_INSERT, 8'h00, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_INSERT, 8'hFF, 1'b1, 1'b1);
      add_beat(bfdh_pkg::OP_QUERY,  8'h00, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_QUERY,  8'hFF, 1'b1, 1'b1);
      add_beat(bfdh_pkg::OP_QUERY,  8'hFF, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_QUERY,  8'h00, 1'b1, 1'b1);
      // Unused operation code is ignored.
      add_beat(OP_UNUSED, 8'hAA, 1'b1, 1'b1);
      // Mixed operations: the last beat decides, so this is an insert.
      add_beat(bfdh_pkg::OP_QUERY,  8'h5A, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_INSERT, 8'hA5, 1'b1, 1'b1);
      // Same key with an empty beat in the middle.
      add_beat(bfdh_pkg::OP_QUERY,  8'h5A, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_QUERY,  8'h77, 1'b0, 1'b0);
      add_beat(bfdh_pkg::OP_INSERT, 8'hA5, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_QUERY,  8'h3C, 1'b0, 1'b1);
      // Partial key dropped by a clear, then queries on the empty store.
      add_beat(bfdh_pkg::OP_INSERT, 8'h11, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_INSERT, 8'h22, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_CLEAR,  8'hC3, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_QUERY,  8'h00, 1'b1, 1'b0);
      add_beat(bfdh_pkg::OP_QUERY,  8'hFF, 1'b1, 1'b1);
      add_beat(bfdh_pkg::OP_QUERY,  8'hA5, 1'b1, 1'b1);
      drain();

      // Random phases over the register settings.
      run_phase(1'b1, 17'd65536,  17'd8,  70, 1'b1, 1'b1, 1'b1);
      run_phase(1'b1, 17'd1,      17'd1,  40, 1'b1, 1'b0, 1'b0);
      run_phase(1'b1, 17'd131071, 17'd15, 60, 1'b0, 1'b0, 1'b0);
      run_phase(1'b0, 17'd300,    17'd3,  40, 1'b1, 1'b1, 1'b0);
      run_phase(1'b1, 17'd0,      17'd5,  30, 1'b1, 1'b1, 1'b0);
      run_phase(1'b1, 17'd97,     17'd0,  30, 1'b0, 1'b1, 1'b0);
      // Responses are held off while the request side keeps sending.
      hold_armed = 1'b1;
      run_phase(1'b1, 17'($urandom_range(8, 4096)), 17'($urandom_range(1, 8)),
                70, 1'b0, 1'b1, 1'b0);
      run_phase(1'b1, 17'd1024, 17'd6, 70, 1'b1, 1'b1, 1'b1);

      if (fail_count == 0) $display("** bloom_filter_double_hash_core: PASSED **");
      else $display("** bloom_filter_double_hash_core: FAILED **");
      $finish;
   end

endmodule

// ----- bloom_filter_double_hash_core.f -----
rtl/bfdh_pkg.sv
rtl/bfdh_req_if.sv
rtl/bfdh_rsp_if.sv
rtl/bfdh_ram.sv
rtl/bfdh_ctrl.sv
rtl/bfdh_dp.sv
rtl/bloom_filter_double_hash_core.sv
dv/bloom_filter_double_hash_core_tb.sv
